/* rtl/par_pkg.sv */
// par_pkg: shared types and constants of the physical access router
// state and command encodings, controller to datapath command and status structs
// no dependencies

package par_pkg;

  localparam int unsigned MAX_PARTS = 8;

  localparam logic CMD_ROUTE  = 1'b0;
  localparam logic CMD_APPEND = 1'b1;

  localparam logic [1:0] MODE_FETCH = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_STORE = 2'd2;
  localparam logic [1:0] MODE_AMO   = 2'd3;

  localparam logic REG_SEL_RAM_START = 1'b0;
  localparam logic REG_SEL_RAM_END   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAULT = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_CHECK,
    S_SCAN_SUB,
    S_SCAN_CMP,
    S_LOOP,
    S_PART,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_FAULT,
    OUT_FULL,
    OUT_APPEND,
    OUT_RAM_WHOLE,
    OUT_REGION_WHOLE,
    OUT_PART
  } out_sel_e;

  typedef struct packed {
    logic     load;
    logic     scan_rst;
    logic     scan_sub;
    logic     scan_next;
    logic     ram_probe;
    logic     take_part;
    out_sel_e out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_append;
    logic perm_ok;
    logic ram_whole;
    logic misaligned;
    logic table_full;
    logic table_empty;
    logic match;
    logic scan_last;
    logic left_zero;
    logic past_top;
    logic in_ram;
    logic emit_last;
  } dp_stat_t;

endpackage

/* rtl/par_ctrl.sv */
// par_ctrl: controller state machine of the physical access router
// sequences permission check, region scan, splitting and part transfer
// depends on par_pkg

module par_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  par_pkg::dp_stat_t  stat_i,
  output par_pkg::dp_cmd_t   cmd_o,
  output logic               busy_o
);
  import par_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat_i.is_append) begin
          state_d = S_APPEND;
        end else if (!stat_i.perm_ok || stat_i.ram_whole) begin
          state_d = S_IDLE;
        end else if (stat_i.misaligned) begin
          state_d = S_LOOP;
        end else if (stat_i.table_empty) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN_SUB;
        end
      end
      S_APPEND:   state_d = S_IDLE;
      S_SCAN_SUB: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        priority if (stat_i.match) begin
          state_d = stat_i.misaligned ? S_PART : S_IDLE;
        end else if (stat_i.scan_last) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN_SUB;
        end
      end
      S_LOOP: begin
        priority if (stat_i.left_zero) begin
          state_d = S_EMIT;
        end else if (stat_i.past_top) begin
          state_d = S_IDLE;
        end else if (stat_i.in_ram) begin
          state_d = S_PART;
        end else if (stat_i.table_empty) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN_SUB;
        end
      end
      S_PART: state_d = S_LOOP;
      S_EMIT: begin
        if (stat_i.emit_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o = '{load: 1'b0, scan_rst: 1'b0, scan_sub: 1'b0, scan_next: 1'b0,
              ram_probe: 1'b0, take_part: 1'b0, out_sel: OUT_NONE};
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
      end
      S_CHECK: begin
        priority if (stat_i.is_append) begin
          cmd_o.out_sel = OUT_NONE;
        end else if (!stat_i.perm_ok) begin
          cmd_o.out_sel = OUT_FAULT;
        end else if (stat_i.ram_whole) begin
          cmd_o.out_sel = OUT_RAM_WHOLE;
        end else if (stat_i.misaligned) begin
          cmd_o.out_sel = OUT_NONE;
        end else if (stat_i.table_empty) begin
          cmd_o.out_sel = OUT_FAULT;
        end else begin
          cmd_o.scan_rst = 1'b1;
        end
      end
      S_APPEND: begin
        cmd_o.out_sel = stat_i.table_full ? OUT_FULL : OUT_APPEND;
      end
      S_SCAN_SUB: begin
        cmd_o.scan_sub = 1'b1;
      end
      S_SCAN_CMP: begin
        priority if (stat_i.match) begin
          cmd_o.out_sel = stat_i.misaligned ? OUT_NONE : OUT_REGION_WHOLE;
        end else if (stat_i.scan_last) begin
          cmd_o.out_sel = OUT_FAULT;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_LOOP: begin
        priority if (stat_i.left_zero) begin
          cmd_o.out_sel = OUT_NONE;
        end else if (stat_i.past_top) begin
          cmd_o.out_sel = OUT_FAULT;
        end else if (stat_i.in_ram) begin
          cmd_o.ram_probe = 1'b1;
        end else if (stat_i.table_empty) begin
          cmd_o.out_sel = OUT_FAULT;
        end else begin
          cmd_o.scan_rst = 1'b1;
        end
      end
      S_PART: begin
        cmd_o.take_part = 1'b1;
      end
      S_EMIT: begin
        cmd_o.out_sel = OUT_PART;
      end
      default: cmd_o.out_sel = OUT_NONE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* rtl/par_datapath.sv */
// par_datapath: region table, address arithmetic, part buffer and result registers
// driven by par_ctrl through dp_cmd_t, reports through dp_stat_t
// depends on par_pkg

module par_datapath #(
  parameter int unsigned MAX_REGIONS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  par_pkg::dp_cmd_t   ctl_i,
  output par_pkg::dp_stat_t  stat_o,
  input  logic               cmd_i,
  input  logic [63:0]        addr_i,
  input  logic [1:0]         size_log2_i,
  input  logic [1:0]         mode_i,
  input  logic               ignore_pmp_i,
  input  logic [2:0]         pmp_perm_i,
  input  logic [63:0]        region_base_i,
  input  logic [63:0]        region_length_i,
  input  logic [63:0]        ram_start_i,
  input  logic [63:0]        ram_end_i,
  output logic [1:0]         status_o,
  output logic               to_ram_o,
  output logic [2:0]         region_index_o,
  output logic [63:0]        offset_o,
  output logic [3:0]         part_bytes_o,
  output logic [2:0]         byte_skip_o,
  output logic               is_write_o,
  output logic               last_o,
  output logic               result_strobe_o
);
  import par_pkg::*;

  localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);
  localparam int unsigned PW = $clog2(MAX_PARTS);

  // item registers
  logic          is_append_q, wr_q, misal_q, perm_ok_q, src_ram_q;
  logic [3:0]    size_q, left_q, done_q;
  logic [63:0]   base_q, length_q, len_q;
  logic [64:0]   a_q, aend_q, diff_q, ediff_q, rend_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] count_q;
  logic [PW:0]   n_q;
  logic [PW-1:0] e_q;

  // region table
  logic [63:0]   bases_q [MAX_REGIONS];
  logic [63:0]   lens_q  [MAX_REGIONS];

  // part buffer
  logic          pb_ram_q  [MAX_PARTS];
  logic [IW-1:0] pb_idx_q  [MAX_PARTS];
  logic [63:0]   pb_off_q  [MAX_PARTS];
  logic [3:0]    pb_len_q  [MAX_PARTS];
  logic [2:0]    pb_skip_q [MAX_PARTS];

  // result registers
  status_e       status_q;
  logic          to_ram_q, is_write_q, last_q, strobe_q;
  logic [2:0]    region_index_q, byte_skip_q;
  logic [63:0]   offset_q;
  logic [3:0]    part_bytes_q;

  logic [3:0]    size_in, size_m1;
  logic          misal_in, need_bit;
  logic [63:0]   b_sel, l_sel, ram_off, ram_len, avail;
  logic [64:0]   diff_s, ediff_s, rend_s, a_step;
  logic          win_short, contain, hit, emit_last;
  logic [3:0]    part;
  logic [IW+2:0] idx_w, pbi_w;
  logic [CW+2:0] cnt_w;
  logic [CW:0]   idx_nx;
  logic [PW:0]   e_nx;

  assign size_in  = 4'd1 << size_log2_i;
  assign size_m1  = size_in - 4'd1;
  assign misal_in = |(addr_i[2:0] & size_m1[2:0]);

  always_comb begin
    unique case (mode_i)
      MODE_FETCH: need_bit = pmp_perm_i[2];
      MODE_LOAD:  need_bit = pmp_perm_i[0];
      default:    need_bit = pmp_perm_i[1];
    endcase
  end

  assign b_sel   = bases_q[idx_q];
  assign l_sel   = lens_q[idx_q];
  assign diff_s  = {1'b0, a_q[63:0]} - {1'b0, b_sel};
  assign ediff_s = aend_q - {1'b0, b_sel};
  assign rend_s  = {1'b0, b_sel} + {1'b0, l_sel};
  assign ram_off = a_q[63:0] - ram_start_i;
  assign ram_len = ram_end_i - ram_start_i;

  // part length: bytes left, or what remains of the current window
  assign avail     = len_q - diff_q[63:0];
  assign win_short = (avail[63:4] == '0) && (avail[3:0] < left_q);
  assign part      = win_short ? avail[3:0] : left_q;
  assign a_step    = a_q + 65'(left_q);

  assign contain = !diff_q[64] && (ediff_q <= {1'b0, len_q});
  assign hit     = !diff_q[64] && (diff_q[63:0] < len_q);

  assign idx_w   = (IW+3)'(idx_q);
  assign pbi_w   = (IW+3)'(pb_idx_q[e_q]);
  assign cnt_w   = (CW+3)'(count_q);
  assign idx_nx  = (CW+1)'(idx_q) + (CW+1)'(1);
  assign e_nx    = (PW+1)'(e_q) + (PW+1)'(1);
  assign emit_last = (e_nx == n_q);

  always_comb begin
    stat_o.is_append   = is_append_q;
    stat_o.perm_ok     = perm_ok_q;
    stat_o.ram_whole   = (a_q >= {1'b0, ram_start_i}) && (aend_q <= {1'b0, ram_end_i});
    stat_o.misaligned  = misal_q;
    stat_o.table_full  = (count_q == CW'(MAX_REGIONS));
    stat_o.table_empty = (count_q == '0);
    stat_o.match       = misal_q ? hit : contain;
    stat_o.scan_last   = (idx_nx == (CW+1)'(count_q));
    stat_o.left_zero   = (left_q == '0);
    stat_o.past_top    = a_q[64];
    stat_o.in_ram      = !a_q[64] && (a_q[63:0] >= ram_start_i) && (a_q[63:0] < ram_end_i);
    stat_o.emit_last   = emit_last;
  end

  // counters and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      n_q      <= '0;
      e_q      <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= (ctl_i.out_sel != OUT_NONE);
      if (ctl_i.out_sel == OUT_APPEND) begin
        count_q <= count_q + CW'(1);
      end
      if (ctl_i.scan_rst) begin
        idx_q <= '0;
      end else if (ctl_i.scan_next) begin
        idx_q <= idx_q + IW'(1);
      end
      if (ctl_i.load) begin
        n_q <= '0;
        e_q <= '0;
      end else begin
        if (ctl_i.take_part) begin
          n_q <= n_q + (PW+1)'(1);
        end
        if (ctl_i.out_sel == OUT_PART) begin
          e_q <= e_q + PW'(1);
        end
      end
    end
  end

  // item, table and part buffer
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      is_append_q <= (cmd_i == CMD_APPEND);
      wr_q        <= (mode_i == MODE_STORE);
      misal_q     <= misal_in;
      perm_ok_q   <= ignore_pmp_i | need_bit;
      size_q      <= size_in;
      base_q      <= region_base_i;
      length_q    <= region_length_i;
      a_q         <= {1'b0, addr_i};
      aend_q      <= {1'b0, addr_i} + 65'(size_in);
      left_q      <= size_in;
      done_q      <= '0;
    end
    if (ctl_i.scan_sub) begin
      diff_q    <= diff_s;
      ediff_q   <= ediff_s;
      len_q     <= l_sel;
      rend_q    <= rend_s;
      src_ram_q <= 1'b0;
    end else if (ctl_i.ram_probe) begin
      diff_q    <= {1'b0, ram_off};
      len_q     <= ram_len;
      rend_q    <= {1'b0, ram_end_i};
      src_ram_q <= 1'b1;
    end
    if (ctl_i.take_part) begin
      pb_ram_q[n_q[PW-1:0]]  <= src_ram_q;
      pb_idx_q[n_q[PW-1:0]]  <= src_ram_q ? '0 : idx_q;
      pb_off_q[n_q[PW-1:0]]  <= diff_q[63:0];
      pb_len_q[n_q[PW-1:0]]  <= part;
      pb_skip_q[n_q[PW-1:0]] <= done_q[2:0];
      a_q    <= win_short ? rend_q : a_step;
      done_q <= done_q + part;
      left_q <= left_q - part;
    end
    if (ctl_i.out_sel == OUT_APPEND) begin
      bases_q[count_q[IW-1:0]] <= base_q;
      lens_q[count_q[IW-1:0]]  <= length_q;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    unique case (ctl_i.out_sel)
      OUT_FAULT, OUT_FULL, OUT_APPEND: begin
        status_q       <= (ctl_i.out_sel == OUT_FAULT) ? ST_FAULT :
                          (ctl_i.out_sel == OUT_FULL)  ? ST_FULL  : ST_OK;
        to_ram_q       <= 1'b0;
        region_index_q <= (ctl_i.out_sel == OUT_APPEND) ? cnt_w[2:0] : 3'd0;
        offset_q       <= '0;
        part_bytes_q   <= '0;
        byte_skip_q    <= '0;
        is_write_q     <= 1'b0;
        last_q         <= 1'b1;
      end
      OUT_RAM_WHOLE: begin
        status_q       <= ST_OK;
        to_ram_q       <= 1'b1;
        region_index_q <= 3'd0;
        offset_q       <= ram_off;
        part_bytes_q   <= size_q;
        byte_skip_q    <= '0;
        is_write_q     <= wr_q;
        last_q         <= 1'b1;
      end
      OUT_REGION_WHOLE: begin
        status_q       <= ST_OK;
        to_ram_q       <= 1'b0;
        region_index_q <= idx_w[2:0];
        offset_q       <= diff_q[63:0];
        part_bytes_q   <= size_q;
        byte_skip_q    <= '0;
        is_write_q     <= wr_q;
        last_q         <= 1'b1;
      end
      OUT_PART: begin
        status_q       <= ST_OK;
        to_ram_q       <= pb_ram_q[e_q];
        region_index_q <= pbi_w[2:0];
        offset_q       <= pb_off_q[e_q];
        part_bytes_q   <= pb_len_q[e_q];
        byte_skip_q    <= pb_skip_q[e_q];
        is_write_q     <= wr_q;
        last_q         <= emit_last;
      end
      default: begin
      end
    endcase
  end

  assign status_o        = status_q;
  assign to_ram_o        = to_ram_q;
  assign region_index_o  = region_index_q;
  assign offset_o        = offset_q;
  assign part_bytes_o    = part_bytes_q;
  assign byte_skip_o     = byte_skip_q;
  assign is_write_o      = is_write_q;
  assign last_o          = last_q;
  assign result_strobe_o = strobe_q;

endmodule

/* rtl/physical_access_router.sv */
// physical_access_router: top level with the configuration registers
// instantiates par_ctrl and par_datapath, depends on par_pkg
//
// An item is taken when start is high and busy is low; its results follow as
// one-cycle pulses on result_strobe_o, back to back, the final one with last_o
// set, and the receiver must take every transfer as it comes. Appending a
// region passes through a check state and an append state. A route that fails
// the permission check or lies wholly in RAM ends in the check state. An
// aligned route into the region table is checked, then searches the table with
// a subtract and a compare state per entry. A misaligned route is checked, then
// takes per part a loop state, a subtract and a compare state per region
// searched for it and a part state, then a last loop state, and sends its parts
// one per cycle. Each result shows in the cycle after the state that made it.

module physical_access_router #(
  parameter int unsigned MAX_REGIONS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [63:0] addr_i,
  input  logic [1:0]  size_log2_i,
  input  logic [1:0]  mode_i,
  input  logic        ignore_pmp_i,
  input  logic [2:0]  pmp_perm_i,
  input  logic [63:0] region_base_i,
  input  logic [63:0] region_length_i,
  output logic [1:0]  status_o,
  output logic        to_ram_o,
  output logic [2:0]  region_index_o,
  output logic [63:0] offset_o,
  output logic [3:0]  part_bytes_o,
  output logic [2:0]  byte_skip_o,
  output logic        is_write_o,
  output logic        last_o,
  output logic        result_strobe_o
);
  import par_pkg::*;

  logic [63:0] ram_start_q, ram_end_q;
  logic        cfg_wr;
  dp_cmd_t     ctl;
  dp_stat_t    stat;

  // configuration port, register select on paddr bit 3
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[3] == REG_SEL_RAM_END) ? ram_end_q : ram_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_start_q <= '0;
      ram_end_q   <= '0;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_SEL_RAM_START) begin
        ram_start_q <= pwdata;
      end else begin
        ram_end_q <= pwdata;
      end
    end
  end

  par_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (ctl),
    .busy_o (busy)
  );

  par_datapath #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .stat_o         (stat),
    .cmd_i          (cmd_i),
    .addr_i         (addr_i),
    .size_log2_i    (size_log2_i),
    .mode_i         (mode_i),
    .ignore_pmp_i   (ignore_pmp_i),
    .pmp_perm_i     (pmp_perm_i),
    .region_base_i  (region_base_i),
    .region_length_i(region_length_i),
    .ram_start_i    (ram_start_q),
    .ram_end_i      (ram_end_q),
    .status_o       (status_o),
    .to_ram_o       (to_ram_o),
    .region_index_o (region_index_o),
    .offset_o       (offset_o),
    .part_bytes_o   (part_bytes_o),
    .byte_skip_o    (byte_skip_o),
    .is_write_o     (is_write_o),
    .last_o         (last_o),
    .result_strobe_o(result_strobe_o)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not make the block busy");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (status_o != ST_OK) |-> last_o && (part_bytes_o == 4'd0))
    else $error("fault or full result is not a lone empty transfer");

  a_parts_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && !last_o |=> result_strobe_o)
    else $error("gap between parts of one access");
`endif

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench of physical_access_router
// drives routes and region appends through the command port and ram limits over apb,
// predicts every transfer and checks it field by field; depends on par_pkg and the rtl

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import par_pkg::*;

  localparam int unsigned NUM_SLOTS = 8;
  localparam logic [63:0] TOP_ADDR = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic        cmd;
    logic [63:0] addr;
    logic [1:0]  size_log2;
    logic [1:0]  mode;
    logic        ign;
    logic [2:0]  perm;
    logic [63:0] base;
    logic [63:0] len;
  } access_t;

  typedef struct {
    logic [1:0]  status;
    logic        to_ram;
    logic [2:0]  region_index;
    logic [63:0] offset;
    logic [3:0]  part_bytes;
    logic [2:0]  byte_skip;
    logic        is_write;
    logic        last;
  } part_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic        cmd_i;
  logic [63:0] addr_i;
  logic [1:0]  size_log2_i;
  logic [1:0]  mode_i;
  logic        ignore_pmp_i;
  logic [2:0]  pmp_perm_i;
  logic [63:0] region_base_i;
  logic [63:0] region_length_i;
  logic [1:0]  status_o;
  logic        to_ram_o;
  logic [2:0]  region_index_o;
  logic [63:0] offset_o;
  logic [3:0]  part_bytes_o;
  logic [2:0]  byte_skip_o;
  logic        is_write_o;
  logic        last_o;
  logic        result_strobe_o;

  logic [63:0] ram_lo = '0;
  logic [63:0] ram_hi = '0;
  logic [63:0] region_base_q [NUM_SLOTS];
  logic [63:0] region_len_q [NUM_SLOTS];
  int          region_count = 0;
  part_t       pending_parts [$];
  int          mismatch_count = 0;

  physical_access_router #(
    .MAX_REGIONS(NUM_SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .addr_i         (addr_i),
    .size_log2_i    (size_log2_i),
    .mode_i         (mode_i),
    .ignore_pmp_i   (ignore_pmp_i),
    .pmp_perm_i     (pmp_perm_i),
    .region_base_i  (region_base_i),
    .region_length_i(region_length_i),
    .status_o       (status_o),
    .to_ram_o       (to_ram_o),
    .region_index_o (region_index_o),
    .offset_o       (offset_o),
    .part_bytes_o   (part_bytes_o),
    .byte_skip_o    (byte_skip_o),
    .is_write_o     (is_write_o),
    .last_o         (last_o),
    .result_strobe_o(result_strobe_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic span_within(logic [63:0] a, logic [63:0] n, logic [63:0] limit);
    return a <= limit && n <= limit - a;
  endfunction

  function automatic void route_access(input access_t it);
    part_t       p;
    part_t       q;
    part_t       parts [$];
    logic [63:0] size;
    logic [63:0] a;
    logic [63:0] left;
    logic [63:0] done;
    logic [63:0] avail;
    logic [63:0] chunk;
    logic        wr;
    logic        perm_ok;
    int          i;
    int          slot;
    p = '{default: '0};
    p.last = 1'b1;
    size = 64'd1 << it.size_log2;
    wr = (it.mode == MODE_STORE);
    if (it.cmd == CMD_APPEND) begin
      if (region_count >= NUM_SLOTS) begin
        p.status = ST_FULL;
      end else begin
        region_base_q[region_count] = it.base;
        region_len_q[region_count] = it.len;
        p.region_index = 3'(region_count);
        region_count++;
      end
      pending_parts.push_back(p);
      return;
    end
    if (!it.ign) begin
      case (it.mode)
        MODE_FETCH: perm_ok = it.perm[2];
        MODE_LOAD:  perm_ok = it.perm[0];
        default:    perm_ok = it.perm[1];
      endcase
      if (!perm_ok) begin
        p.status = ST_FAULT;
        pending_parts.push_back(p);
        return;
      end
    end
    if (it.addr >= ram_lo && span_within(it.addr, size, ram_hi)) begin
      p.to_ram = 1'b1;
      p.offset = it.addr - ram_lo;
      p.part_bytes = size[3:0];
      p.is_write = wr;
      pending_parts.push_back(p);
      return;
    end
    p.status = ST_FAULT;
    if ((it.addr & (size - 64'd1)) != 0) begin
      a = it.addr;
      left = size;
      done = '0;
      while (left != 0) begin
        // wrapped past the top of the address space
        if (it.addr > a) begin
          pending_parts.push_back(p);
          return;
        end
        q = '{default: '0};
        q.is_write = wr;
        q.byte_skip = done[2:0];
        if (a >= ram_lo && a < ram_hi) begin
          avail = ram_hi - a;
          q.to_ram = 1'b1;
          q.offset = a - ram_lo;
        end else begin
          slot = -1;
          for (i = 0; i < region_count && slot < 0; i++) begin
            if (a >= region_base_q[i] && a - region_base_q[i] < region_len_q[i]) slot = i;
          end
          if (slot < 0) begin
            pending_parts.push_back(p);
            return;
          end
          avail = region_len_q[slot] - (a - region_base_q[slot]);
          q.region_index = 3'(slot);
          q.offset = a - region_base_q[slot];
        end
        chunk = (left < avail) ? left : avail;
        q.part_bytes = chunk[3:0];
        parts.push_back(q);
        a += chunk;
        done += chunk;
        left -= chunk;
      end
      parts[parts.size() - 1].last = 1'b1;
      foreach (parts[k]) pending_parts.push_back(parts[k]);
      return;
    end
    for (i = 0; i < region_count; i++) begin
      if (it.addr >= region_base_q[i] &&
          span_within(it.addr - region_base_q[i], size, region_len_q[i])) begin
        p.status = ST_OK;
        p.region_index = 3'(i);
        p.offset = it.addr - region_base_q[i];
        p.part_bytes = size[3:0];
        p.is_write = wr;
        pending_parts.push_back(p);
        return;
      end
    end
    pending_parts.push_back(p);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    part_t want;
    if (rst_ni && result_strobe_o) begin
      if (pending_parts.size() == 0) begin
        report_mismatch("transfer with nothing expected", status_o, '0);
      end else begin
        want = pending_parts.pop_front();
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (to_ram_o !== want.to_ram) report_mismatch("to_ram", to_ram_o, want.to_ram);
        if (region_index_o !== want.region_index)
          report_mismatch("region_index", region_index_o, want.region_index);
        if (offset_o !== want.offset) report_mismatch("offset", offset_o, want.offset);
        if (part_bytes_o !== want.part_bytes)
          report_mismatch("part_bytes", part_bytes_o, want.part_bytes);
        if (byte_skip_o !== want.byte_skip)
          report_mismatch("byte_skip", byte_skip_o, want.byte_skip);
        if (is_write_o !== want.is_write) report_mismatch("is_write", is_write_o, want.is_write);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic access_t access_item(logic [63:0] addr, logic [1:0] size_log2,
                                          logic [1:0] mode, logic ign, logic [2:0] perm);
    access_t it;
    it.cmd = CMD_ROUTE;
    it.addr = addr;
    it.size_log2 = size_log2;
    it.mode = mode;
    it.ign = ign;
    it.perm = perm;
    it.base = {$urandom, $urandom};
    it.len = {$urandom, $urandom};
    return it;
  endfunction

  function automatic access_t append_item(logic [63:0] base, logic [63:0] len);
    access_t it;
    it = access_item({$urandom, $urandom}, 2'($urandom), 2'($urandom), 1'($urandom),
                     3'($urandom));
    it.cmd = CMD_APPEND;
    it.base = base;
    it.len = len;
    return it;
  endfunction

  // mostly near ram and region edges, where the splitting happens
  function automatic access_t random_access();
    access_t     it;
    logic [63:0] marks [$];
    int          pick;
    int          i;
    marks = '{ram_lo, ram_hi, 64'd0, TOP_ADDR};
    for (i = 0; i < region_count; i++) begin
      marks.push_back(region_base_q[i]);
      marks.push_back(region_base_q[i] + region_len_q[i]);
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) return append_item({$urandom, $urandom}, {$urandom, $urandom});
    it = access_item({$urandom, $urandom}, 2'($urandom), 2'($urandom),
                     $urandom_range(0, 3) != 0, 3'($urandom));
    if (pick >= 25)
      it.addr = marks[$urandom_range(0, marks.size() - 1)] - 64'd8 + 64'($urandom_range(0, 16));
    return it;
  endfunction

  task automatic send_item(input access_t it);
    int gap;
    cmd_i <= it.cmd;
    addr_i <= it.addr;
    size_log2_i <= it.size_log2;
    mode_i <= it.mode;
    ignore_pmp_i <= it.ign;
    pmp_perm_i <= it.perm;
    region_base_i <= it.base;
    region_length_i <= it.len;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    route_access(it);
    gap = idle_cycles();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_parts.size() != 0 || busy) @(posedge clk_i);
  endtask

  task automatic write_reg(logic sel, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 3'b000};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_SEL_RAM_START) ram_lo = value;
    else ram_hi = value;
  endtask

  task automatic set_ram(logic [63:0] lo, logic [63:0] hi);
    write_reg(REG_SEL_RAM_START, lo);
    write_reg(REG_SEL_RAM_END, hi);
  endtask

  task automatic test_empty_table();
    send_item(access_item(64'd0, 2'd3, MODE_LOAD, 1'b1, 3'b000));
    send_item(access_item(TOP_ADDR, 2'd0, MODE_STORE, 1'b1, 3'b000));
    settle();
  endtask

  task automatic test_region_table();
    send_item(append_item(64'h1000_0000, 64'h100));
    send_item(append_item(64'h1000_0100, 64'h3));
    send_item(append_item(64'h1000_0103, 64'h1));
    send_item(append_item(64'h1000_0104, 64'h0));
    send_item(append_item(64'h1000_0080, 64'h1000));
    send_item(append_item(64'hFFFF_FFFF_FFFF_FF00, 64'h100));
    send_item(append_item(64'h8001_0000, 64'h1000));
    send_item(append_item(64'h7FFF_FFF8, 64'h8));
    send_item(append_item(TOP_ADDR, TOP_ADDR));
    settle();
  endtask

  task automatic test_permissions();
    send_item(access_item(64'h8000_0010, 2'd1, MODE_FETCH, 1'b0, 3'b011));
    send_item(access_item(64'h8000_0010, 2'd1, MODE_FETCH, 1'b0, 3'b100));
    send_item(access_item(64'h8000_0010, 2'd1, MODE_LOAD, 1'b0, 3'b110));
    send_item(access_item(64'h8000_0010, 2'd1, MODE_STORE, 1'b0, 3'b010));
    send_item(access_item(64'h8000_0010, 2'd1, MODE_AMO, 1'b0, 3'b101));
    settle();
  endtask

  task automatic test_routing();
    send_item(access_item(64'h8000_0000, 2'd3, MODE_STORE, 1'b1, 3'b000));
    // overlapping regions, empty region, splits across region and ram edges
    send_item(access_item(64'h1000_0080, 2'd2, MODE_AMO, 1'b1, 3'b000));
    send_item(access_item(64'h1000_0100, 2'd2, MODE_FETCH, 1'b1, 3'b000));
    send_item(access_item(64'h1000_00FE, 2'd3, MODE_STORE, 1'b1, 3'b000));
    send_item(access_item(64'h8000_FFFD, 2'd3, MODE_LOAD, 1'b1, 3'b000));
    send_item(access_item(64'h7FFF_FFFD, 2'd3, MODE_LOAD, 1'b1, 3'b000));
    send_item(access_item(64'hFFFF_FFFF_FFFF_FFFD, 2'd2, MODE_LOAD, 1'b1, 3'b000));
    send_item(access_item(64'hFFFF_FFFF_FFFF_FFF8, 2'd3, MODE_STORE, 1'b1, 3'b000));
    send_item(access_item(64'h1000_107F, 2'd1, MODE_LOAD, 1'b1, 3'b000));
    send_item(access_item(64'd0, 2'd0, MODE_FETCH, 1'b1, 3'b000));
    send_item(access_item(64'h1000_0104, 2'd0, MODE_LOAD, 1'b1, 3'b000));
    settle();
  endtask

  task automatic test_random_routing();
    logic [63:0] lows [7];
    logic [63:0] highs [7];
    int          s;
    lows = '{64'h8000_0000, 64'd0, 64'h8001_0000, 64'h1000_0000, TOP_ADDR - 64'hFFF,
             64'h1000_00F0, {$urandom, $urandom}};
    highs = '{64'h8001_0000, TOP_ADDR, 64'h8000_0000, 64'h1000_0000, TOP_ADDR,
              64'h1000_0110, {$urandom, $urandom}};
    for (s = 0; s < 7; s++) begin
      set_ram(lows[s], highs[s]);
      repeat (53) send_item(random_access());
      settle();
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    cmd_i <= CMD_ROUTE;
    addr_i <= '0;
    size_log2_i <= '0;
    mode_i <= MODE_FETCH;
    ignore_pmp_i <= 1'b0;
    pmp_perm_i <= '0;
    region_base_i <= '0;
    region_length_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    set_ram(64'h8000_0000, 64'h8001_0000);
    test_region_table();
    test_permissions();
    test_routing();
    test_random_routing();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && pending_parts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
